// File: rtl/core/npc_pkg.sv
// Shared types, constants and distance function for the nearest palette color search.
`default_nettype none
package npc_pkg;

    localparam int PALETTE_DEPTH_DEFAULT = 256;
    localparam int MAX_INDEXES = 256;
    localparam int DIST_WIDTH = 18;
    localparam logic [8:0] SIZE_RESET = 9'd2;
    localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

    typedef enum logic {
        OP_LOAD     = 1'b0,
        OP_QUANTIZE = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    localparam color_t COLOR_BLACK = '{red: 8'd0, green: 8'd0, blue: 8'd0};
    localparam color_t COLOR_WHITE = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF};

    typedef struct packed {
        logic                  valid;
        opcode_t               opcode;
        logic [7:0]            entry_index;
        color_t                pixel;
        logic [7:0]            best_index;
        color_t                best_color;
        logic [DIST_WIDTH-1:0] best_dist;
    } item_t;

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return {8'd0, d} * {8'd0, d};
    endfunction

    function automatic logic [DIST_WIDTH-1:0] color_dist(input color_t a, input color_t b);
        return DIST_WIDTH'(sq_diff(a.red, b.red)) + DIST_WIDTH'(sq_diff(a.green, b.green))
            + DIST_WIDTH'(sq_diff(a.blue, b.blue));
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/npc_cell.sv
// One palette entry of the search chain: distance stage followed by compare stage.
`default_nettype none
module npc_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           advance,
    input  wire logic           active,
    input  wire npc_pkg::item_t item_in,
    output npc_pkg::item_t      item_out
);

    localparam logic [7:0] MY_INDEX = 8'(CELL_INDEX);
    localparam npc_pkg::color_t ENTRY_RESET =
        (CELL_INDEX == 1) ? npc_pkg::COLOR_WHITE : npc_pkg::COLOR_BLACK;

    npc_pkg::color_t                   entry_reg;
    npc_pkg::item_t                    mid_reg;
    npc_pkg::color_t                   mid_color_reg;
    logic [npc_pkg::DIST_WIDTH-1:0]    mid_dist_reg;
    npc_pkg::item_t                    out_reg;
    npc_pkg::item_t                    out_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= ENTRY_RESET;
            mid_reg   <= '0;
        end else if (advance) begin
            if (item_in.valid && item_in.opcode == npc_pkg::OP_LOAD &&
                item_in.entry_index == MY_INDEX) begin
                entry_reg <= item_in.pixel;
            end
            mid_reg <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mid_color_reg <= entry_reg;
            mid_dist_reg  <= npc_pkg::color_dist(item_in.pixel, entry_reg);
        end
    end

    always_comb begin
        out_next = mid_reg;
        if (mid_reg.valid && mid_reg.opcode == npc_pkg::OP_QUANTIZE && active &&
            mid_dist_reg < mid_reg.best_dist) begin
            out_next.best_dist  = mid_dist_reg;
            out_next.best_index = MY_INDEX;
            out_next.best_color = mid_color_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg <= '0;
        end else if (advance) begin
            out_reg <= out_next;
        end
    end

    assign item_out = out_reg;

endmodule
`default_nettype wire

// File: rtl/core/nearest_palette_color.sv
// Each palette entry is a two-stage cell of the search chain; every item passes through all cells.
// Throughput: one item per cycle while the output is not stalled.
// Load items flow down the chain and write their cell in order, and give no result.
// A downstream stall holds the whole chain.
// Reset: palette entry 1 is white, all others black, palette_size is 2, pipeline empties.
// Writes to entries at or above PALETTE_DEPTH are dropped.
`default_nettype none
module nearest_palette_color #(
    parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,   // palette_size[8:0], zero fill
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // entry_index, red_in, green_in, blue_in
    input  wire logic [0:0]  s_tuser,    // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata     // chosen_index, red_out, green_out, blue_out,
                                         // red_error, green_error, blue_error, zero fill
);

    localparam int NUM_CELLS =
        (PALETTE_DEPTH < npc_pkg::MAX_INDEXES) ? PALETTE_DEPTH : npc_pkg::MAX_INDEXES;

    logic [8:0]     size_reg;
    logic           advance;
    npc_pkg::item_t head;
    npc_pkg::item_t chain [NUM_CELLS+1];

    logic           out_valid_reg;
    logic [7:0]     out_index_reg;
    npc_pkg::color_t out_color_reg;
    logic [8:0]     out_red_err_reg;
    logic [8:0]     out_green_err_reg;
    logic [8:0]     out_blue_err_reg;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= npc_pkg::SIZE_RESET;
        end else if (cfg_valid) begin
            size_reg <= cfg_data[8:0];
        end
    end

    always_comb begin
        head             = '0;
        head.valid       = s_tvalid;
        head.opcode      = npc_pkg::opcode_t'(s_tuser[0]);
        head.entry_index = s_tdata[7:0];
        head.pixel.red   = s_tdata[15:8];
        head.pixel.green = s_tdata[23:16];
        head.pixel.blue  = s_tdata[31:24];
        head.best_dist   = npc_pkg::DIST_MAX;
    end

    assign chain[0] = head;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        logic active;
        assign active = (i == 0) || (size_reg > 9'(i));
        npc_cell #(
            .CELL_INDEX(i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .active  (active),
            .item_in (chain[i]),
            .item_out(chain[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= chain[NUM_CELLS].valid &&
                chain[NUM_CELLS].opcode == npc_pkg::OP_QUANTIZE;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_index_reg     <= chain[NUM_CELLS].best_index;
            out_color_reg     <= chain[NUM_CELLS].best_color;
            out_red_err_reg   <= {1'b0, chain[NUM_CELLS].pixel.red}
                - {1'b0, chain[NUM_CELLS].best_color.red};
            out_green_err_reg <= {1'b0, chain[NUM_CELLS].pixel.green}
                - {1'b0, chain[NUM_CELLS].best_color.green};
            out_blue_err_reg  <= {1'b0, chain[NUM_CELLS].pixel.blue}
                - {1'b0, chain[NUM_CELLS].best_color.blue};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_blue_err_reg, out_green_err_reg, out_red_err_reg,
                       out_color_reg.blue, out_color_reg.green, out_color_reg.red,
                       out_index_reg};

endmodule
`default_nettype wire
